### hdl/smiles_atomwise_tokenizer_core_assert.svh
// Assertion macros for the SMILES tokenizer core.
`ifndef SMILES_ATOMWISE_TOKENIZER_CORE_ASSERT_SVH
`define SMILES_ATOMWISE_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SATOK_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("satok: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SATOK_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("satok: next-cycle check failed");

`endif

### hdl/satok_pkg.sv
// Types, character codes and token scan functions shared by the tokenizer modules.
package satok_pkg;

   localparam int POS_W       = 12;
   localparam int MAX_RESULTS = 34;

   localparam logic [2:0] KIND_BRACKET = 3'd0;
   localparam logic [2:0] KIND_BR      = 3'd1;
   localparam logic [2:0] KIND_B       = 3'd2;
   localparam logic [2:0] KIND_CL      = 3'd3;
   localparam logic [2:0] KIND_C       = 3'd4;
   localparam logic [2:0] KIND_SINGLE  = 3'd5;
   localparam logic [2:0] KIND_PERCENT = 3'd6;
   localparam logic [2:0] KIND_DIGIT   = 3'd7;

   localparam logic [7:0] CH_UPPER_B = 8'h42;
   localparam logic [7:0] CH_UPPER_C = 8'h43;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_L = 8'h6C;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_NUL     = 8'h00;

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_B       = 6'b000010,
      MODE_C       = 6'b000100,
      MODE_PCT     = 6'b001000,
      MODE_PCT1    = 6'b010000,
      MODE_BRACKET = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0] token_start;
      logic [POS_W-1:0] token_length;
      logic [2:0]       token_kind;
      logic [7:0]       first_byte;
      logic             overflow;
      logic             run_last;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type tok;
   } slot_type;

   typedef struct packed {
      mode_type         mode;
      logic [POS_W-1:0] start;
      logic [7:0]       held;
      slot_type         r0;
      slot_type         r1;
   } feed_type;

   // token hand-off from the scan control to the output stage
   typedef struct packed {
      logic            push;
      logic            done;
      rsp_payload_type tok;
   } gen_type;

   function automatic rsp_payload_type make_tok(logic [POS_W-1:0] start,
                                                logic [POS_W-1:0] len,
                                                logic [2:0] kind,
                                                logic [7:0] first,
                                                logic ovf);
      rsp_payload_type t;
      t.token_start  = start;
      t.token_length = len;
      t.token_kind   = kind;
      t.first_byte   = first;
      t.overflow     = ovf;
      t.run_last     = 1'b0;
      return t;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
   endfunction

   function automatic logic is_single(logic [7:0] c);
      logic hit;
      unique case (c)
         8'h4E, 8'h4F, 8'h53, 8'h50, 8'h46, 8'h49,          // N O S P F I
         8'h62, 8'h63, 8'h6E, 8'h6F, 8'h73, 8'h70,          // b c n o s p
         8'h28, 8'h29, 8'h2E, 8'h3D, 8'h23, 8'h2D, 8'h2B,   // ( ) . = # - +
         8'h5C, 8'h2F, 8'h3A, 8'h7E, 8'h40, 8'h3F, 8'h3E,   // \ / : ~ @ ? >
         8'h2A, 8'h24: begin                                // * $
            hit = 1'b1;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      return hit;
   endfunction

   // One byte against the held form: r0 resolves the held form, r1 is the byte itself.
   function automatic feed_type feed(mode_type mode, logic [POS_W-1:0] start,
                                     logic [7:0] held, logic [7:0] c,
                                     logic [POS_W-1:0] p, logic brackets);
      feed_type f;
      logic     cont;
      f.mode  = MODE_IDLE;
      f.start = start;
      f.held  = held;
      f.r0    = '0;
      f.r1    = '0;
      cont    = 1'b1;
      unique case (mode)
         MODE_B: begin
            f.r0.valid = 1'b1;
            if (c == CH_LOWER_R) begin
               f.r0.tok = make_tok(start, POS_W'(2), KIND_BR, CH_UPPER_B, 1'b0);
               cont     = 1'b0;
            end else begin
               f.r0.tok = make_tok(start, POS_W'(1), KIND_B, CH_UPPER_B, 1'b0);
            end
         end
         MODE_C: begin
            f.r0.valid = 1'b1;
            if (c == CH_LOWER_L) begin
               f.r0.tok = make_tok(start, POS_W'(2), KIND_CL, CH_UPPER_C, 1'b0);
               cont     = 1'b0;
            end else begin
               f.r0.tok = make_tok(start, POS_W'(1), KIND_C, CH_UPPER_C, 1'b0);
            end
         end
         MODE_PCT: begin
            if (is_digit(c)) begin
               f.mode = MODE_PCT1;
               f.held = c;
               cont   = 1'b0;
            end
         end
         MODE_PCT1: begin
            f.r0.valid = 1'b1;
            if (is_digit(c)) begin
               f.r0.tok = make_tok(start, POS_W'(3), KIND_PERCENT, CH_PERCENT, 1'b0);
               cont     = 1'b0;
            end else begin
               // percent with one digit: only the digit counts
               f.r0.tok = make_tok(start + POS_W'(1), POS_W'(1), KIND_DIGIT, held, 1'b0);
            end
         end
         default: begin
            cont = 1'b1;
         end
      endcase
      if (cont) begin
         priority if (c == CH_UPPER_B) begin
            f.mode  = MODE_B;
            f.start = p;
         end else if (c == CH_UPPER_C) begin
            f.mode  = MODE_C;
            f.start = p;
         end else if (c == CH_PERCENT) begin
            f.mode  = MODE_PCT;
            f.start = p;
         end else if ((c == CH_LBRACK) && brackets) begin
            f.mode  = MODE_BRACKET;
            f.start = p;
         end else if (is_digit(c)) begin
            f.r1.valid = 1'b1;
            f.r1.tok   = make_tok(p, POS_W'(1), KIND_DIGIT, c, 1'b0);
         end else if (is_single(c)) begin
            f.r1.valid = 1'b1;
            f.r1.tok   = make_tok(p, POS_W'(1), KIND_SINGLE, c, 1'b0);
         end else begin
            f.r1.valid = 1'b0;
         end
      end
      return f;
   endfunction

   // End of input: a held B or C stands alone, a percent with one digit leaves the digit, a lone percent is dropped.
   function automatic slot_type flush(mode_type mode, logic [POS_W-1:0] start,
                                      logic [7:0] held);
      slot_type s;
      s = '0;
      unique case (mode)
         MODE_B: begin
            s.valid = 1'b1;
            s.tok   = make_tok(start, POS_W'(1), KIND_B, CH_UPPER_B, 1'b0);
         end
         MODE_C: begin
            s.valid = 1'b1;
            s.tok   = make_tok(start, POS_W'(1), KIND_C, CH_UPPER_C, 1'b0);
         end
         MODE_PCT1: begin
            s.valid = 1'b1;
            s.tok   = make_tok(start + POS_W'(1), POS_W'(1), KIND_DIGIT, held, 1'b0);
         end
         default: begin
            s.valid = 1'b0;
         end
      endcase
      return s;
   endfunction

endpackage

### hdl/satok_store.sv
// Bracket contents store: one write port, one read port with registered read data.
module satok_store #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/satok_emit.sv
// Output stage: one-token hold to find the last token of an item, then the output register.
module satok_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  satok_pkg::gen_type        gen,
   output logic                      gen_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output satok_pkg::rsp_payload_type rsp_payload
);

   logic                       out_valid_ff, out_valid_in;
   satok_pkg::rsp_payload_type out_ff, out_in;
   logic                       hold_valid_ff, hold_valid_in;
   logic                       hold_last_ff, hold_last_in;
   satok_pkg::rsp_payload_type hold_ff, hold_in;
   logic                       out_free;
   logic                       move;

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      gen_ready = !hold_valid_ff || out_free;
      // the held token leaves once we know whether it closes its item
      move = hold_valid_ff && out_free && (hold_last_ff || gen.push || gen.done);

      out_valid_in = move ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
      out_in       = out_ff;
      if (move) begin
         out_in          = hold_ff;
         out_in.run_last = hold_last_ff || (gen.done && !gen.push);
      end

      hold_valid_in = gen.push ? 1'b1 : (move ? 1'b0 : hold_valid_ff);
      hold_in       = gen.push ? gen.tok : hold_ff;
      hold_last_in  = gen.push ? gen.done : (gen.done ? 1'b1 : hold_last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         hold_last_ff  <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
         hold_last_ff  <= hold_last_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

### hdl/smiles_atomwise_tokenizer_core.sv
// Atom-wise SMILES tokenizer: one string byte per item, tokens leave in string order.
// Tokens go through the hold and output registers of satok_emit. One item per cycle when it
//   yields at most one token and gen_ready is high; a second token stalls input in ST_DRAIN.
// End of string in an open bracket: n <= BRACKET_DEPTH stored bytes are rescanned, one read
//   per cycle from the bracket store while gen_ready is high and no second token spills.
// Reset: synchronous, active high; clears position, held form and valids, not the store.
`include "smiles_atomwise_tokenizer_core_assert.svh"

module smiles_atomwise_tokenizer_core #(
   parameter int BRACKET_DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  satok_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output satok_pkg::rsp_payload_type rsp_payload
);

   localparam int IDX_W = $clog2(BRACKET_DEPTH);
   localparam int CNT_W = $clog2(BRACKET_DEPTH + 2);
   localparam int RES_W = $clog2(satok_pkg::MAX_RESULTS + 1);
   localparam int POS_W = satok_pkg::POS_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BRACKET_DEPTH);
   localparam logic [RES_W-1:0] RES_CAP = RES_W'(satok_pkg::MAX_RESULTS);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DRAIN    = 7'b0000010,
      ST_RS_START = 7'b0000100,
      ST_RS_FEED  = 7'b0001000,
      ST_RS_SPILL = 7'b0010000,
      ST_RS_FLUSH = 7'b0100000,
      ST_RS_OVF   = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   satok_pkg::mode_type        mode_ff, mode_in;
   logic [POS_W-1:0]           start_ff, start_in;
   logic [7:0]                 held_ff, held_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [POS_W-1:0]           rs_pos_ff, rs_pos_in;
   satok_pkg::rsp_payload_type extra_ff, extra_in;
   logic [RES_W-1:0]           res_cnt_ff, res_cnt_in;

   satok_pkg::gen_type         gen;
   logic                       gen_ready;
   logic                       accept;
   logic                       wr_en;
   logic [IDX_W-1:0]           rd_addr;
   logic [7:0]                 rd_data;
   logic                       advance;
   satok_pkg::slot_type        cand;
   logic                       cand_done;
   logic [RES_W-1:0]           cnt_base;

   // main step terms
   satok_pkg::feed_type        mf;
   logic                       in_bracket, close;
   satok_pkg::mode_type        m_mode;
   logic [POS_W-1:0]           m_start;
   logic [7:0]                 m_held;
   logic [CNT_W-1:0]           m_count;
   satok_pkg::slot_type        r0, r1, r2, mfl;
   satok_pkg::slot_type        m_first, m_second;
   logic                       m_rescan;

   // rescan terms
   satok_pkg::feed_type        lf;
   satok_pkg::slot_type        l_first, l_second, lfl;
   logic [CNT_W-1:0]           n_eff;
   logic                       last_byte, over;

   // rescan exit terms for the checks below
   logic                       rs_exit, rs_clear;

   satok_store #(
      .DEPTH  (BRACKET_DEPTH),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_payload.ch),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   satok_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .gen         (gen),
      .gen_ready   (gen_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   assign req_stall = (state_ff != ST_IDLE) || !gen_ready;
   assign accept    = req_valid && !req_stall;

   // one input byte against the live state
   always_comb begin
      in_bracket = (mode_ff == satok_pkg::MODE_BRACKET);
      close      = (req_payload.ch == satok_pkg::CH_RBRACK);
      mf = satok_pkg::feed(mode_ff, start_ff, held_ff, req_payload.ch, pos_ff, 1'b1);
      if (in_bracket) begin
         m_mode  = close ? satok_pkg::MODE_IDLE : satok_pkg::MODE_BRACKET;
         m_start = start_ff;
         m_held  = held_ff;
         m_count = close ? '0 : ((count_ff <= DEPTH_C) ? count_ff + CNT_W'(1) : count_ff);
         // empty brackets give nothing
         r0.valid = close && (count_ff != '0);
         r0.tok   = satok_pkg::make_tok(start_ff, pos_ff - start_ff + POS_W'(1),
                                        satok_pkg::KIND_BRACKET, satok_pkg::CH_LBRACK, 1'b0);
         r1 = '0;
      end else begin
         m_mode  = mf.mode;
         m_start = mf.start;
         m_held  = mf.held;
         m_count = (mf.mode == satok_pkg::MODE_BRACKET) ? '0 : count_ff;
         r0 = mf.r0;
         r1 = mf.r1;
      end
      m_rescan = req_payload.end_of_string && (m_mode == satok_pkg::MODE_BRACKET);
      mfl      = satok_pkg::flush(m_mode, m_start, m_held);
      r2.valid = req_payload.end_of_string && mfl.valid;
      r2.tok   = mfl.tok;

      m_first.valid  = r0.valid || r1.valid || r2.valid;
      m_first.tok    = r0.valid ? r0.tok : (r1.valid ? r1.tok : r2.tok);
      m_second.valid = r0.valid && (r1.valid || r2.valid);
      m_second.tok   = r1.valid ? r1.tok : r2.tok;
   end

   // one stored byte of an unclosed bracket, brackets not recognized
   always_comb begin
      lf = satok_pkg::feed(mode_ff, start_ff, held_ff, rd_data, rs_pos_ff, 1'b0);
      l_first.valid  = lf.r0.valid || lf.r1.valid;
      l_first.tok    = lf.r0.valid ? lf.r0.tok : lf.r1.tok;
      l_second.valid = lf.r0.valid && lf.r1.valid;
      l_second.tok   = lf.r1.tok;
      lfl       = satok_pkg::flush(mode_ff, start_ff, held_ff);
      over      = count_ff > DEPTH_C;
      n_eff     = over ? DEPTH_C : count_ff;
      last_byte = (CNT_W'(idx_ff) + CNT_W'(1)) == n_eff;
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      mode_in   = mode_ff;
      start_in  = start_ff;
      held_in   = held_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      rs_pos_in = rs_pos_ff;
      extra_in  = extra_ff;
      cand      = '0;
      cand_done = 1'b0;
      advance   = 1'b0;
      wr_en     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cand      = m_first;
               cand_done = !m_second.valid && !m_rescan;
               wr_en     = in_bracket && !close && (count_ff < DEPTH_C);
               extra_in  = m_second.tok;
               held_in   = m_held;
               count_in  = m_count;
               idx_in    = '0;
               rs_pos_in = m_start + POS_W'(1);
               if (m_rescan) begin
                  // position stays: the overflow marker measures up to this byte
                  mode_in  = satok_pkg::MODE_IDLE;
                  start_in = m_start;
                  state_in = ST_RS_START;
               end else if (req_payload.end_of_string) begin
                  pos_in   = '0;
                  mode_in  = satok_pkg::MODE_IDLE;
                  start_in = '0;
                  count_in = '0;
                  state_in = m_second.valid ? ST_DRAIN : ST_IDLE;
               end else begin
                  pos_in   = pos_ff + POS_W'(1);
                  mode_in  = m_mode;
                  start_in = m_start;
                  state_in = m_second.valid ? ST_DRAIN : ST_IDLE;
               end
            end
         end
         ST_DRAIN: begin
            cand.valid = 1'b1;
            cand.tok   = extra_ff;
            cand_done  = 1'b1;
            if (gen_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_RS_START: begin
            state_in = (count_ff == '0) ? ST_RS_FLUSH : ST_RS_FEED;
         end
         ST_RS_FEED: begin
            cand = l_first;
            if (gen_ready) begin
               mode_in   = lf.mode;
               start_in  = lf.start;
               held_in   = lf.held;
               rs_pos_in = rs_pos_ff + POS_W'(1);
               extra_in  = l_second.tok;
               if (l_second.valid) begin
                  state_in = ST_RS_SPILL;
               end else if (last_byte) begin
                  state_in = ST_RS_FLUSH;
               end else begin
                  advance = 1'b1;
                  idx_in  = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_RS_SPILL: begin
            cand.valid = 1'b1;
            cand.tok   = extra_ff;
            if (gen_ready) begin
               if (last_byte) begin
                  state_in = ST_RS_FLUSH;
               end else begin
                  advance  = 1'b1;
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_RS_FEED;
               end
            end
         end
         ST_RS_FLUSH: begin
            cand      = lfl;
            cand_done = !over;
            if (!lfl.valid || gen_ready) begin
               if (over) begin
                  state_in = ST_RS_OVF;
               end else begin
                  pos_in   = '0;
                  mode_in  = satok_pkg::MODE_IDLE;
                  start_in = '0;
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RS_OVF: begin
            // rs_pos now points at the first byte that did not fit
            cand.valid = 1'b1;
            cand.tok   = satok_pkg::make_tok(rs_pos_ff, pos_ff - rs_pos_ff + POS_W'(1),
                                             satok_pkg::KIND_BRACKET, satok_pkg::CH_NUL, 1'b1);
            cand_done  = 1'b1;
            if (gen_ready) begin
               pos_in   = '0;
               mode_in  = satok_pkg::MODE_IDLE;
               start_in = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // tokens past the cap of one item are dropped
      cnt_base   = (state_ff == ST_IDLE) ? '0 : res_cnt_ff;
      gen.push   = cand.valid && gen_ready && (cnt_base < RES_CAP);
      gen.done   = cand_done && (!cand.valid || gen_ready);
      gen.tok    = cand.tok;
      res_cnt_in = cnt_base + RES_W'(gen.push);
      rd_addr    = advance ? idx_ff + IDX_W'(1) : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         mode_ff    <= satok_pkg::MODE_IDLE;
         start_ff   <= '0;
         count_ff   <= '0;
         idx_ff     <= '0;
         res_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         mode_ff    <= mode_in;
         start_ff   <= start_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff   <= held_in;
      rs_pos_ff <= rs_pos_in;
      extra_ff  <= extra_in;
   end

   assign rs_exit  = (state_ff == ST_RS_FLUSH || state_ff == ST_RS_OVF) && (state_in == ST_IDLE);
   assign rs_clear = (pos_ff == '0) && (count_ff == '0) && (mode_ff == satok_pkg::MODE_IDLE);

   `SATOK_ASSERT_IMP(a_no_store_write_busy, state_ff != ST_IDLE, !wr_en)
   `SATOK_ASSERT_IMP(a_result_cap, 1'b1, res_cnt_ff <= RES_CAP)
   `SATOK_ASSERT_IMP(a_rescan_no_bracket, state_ff == ST_RS_FEED, mode_ff != satok_pkg::MODE_BRACKET)
   `SATOK_ASSERT_NEXT(a_rescan_clears, rs_exit, rs_clear)

endmodule

### tb/satok_token_checker.sv
// Token checker: predicts the tokens of each accepted byte and compares them with the core output.
`timescale 1ns / 1ps

module satok_token_checker #(
   parameter int DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  satok_pkg::req_payload_type req_payload,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  satok_pkg::rsp_payload_type rsp_payload,
   output int                         fail_count,
   output int                         pending_count,
   output int                         token_count,
   output int                         marker_count
);

   localparam int    POS_W   = satok_pkg::POS_W;
   localparam string SYMBOLS = "NOSPFIbcnosp().=#-+\\/:~@?>*$";

   // predictor state
   logic [POS_W-1:0]           str_pos;
   logic [POS_W-1:0]           held_start;
   satok_pkg::mode_type        held_mode;
   logic [7:0]                 bracket_buf [DEPTH];
   int                         bracket_len;

   satok_pkg::rsp_payload_type step_toks[$];
   satok_pkg::rsp_payload_type expected_toks[$];
   int                         errors;
   int                         checked;
   int                         markers;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      token_count   = 0;
      marker_count  = 0;
      errors        = 0;
      checked       = 0;
      markers       = 0;
   end

   function automatic logic is_num(logic [7:0] c);
      return (c >= satok_pkg::CH_DIGIT_0) && (c <= satok_pkg::CH_DIGIT_9);
   endfunction

   function automatic logic is_sym(logic [7:0] c);
      for (int i = 0; i < SYMBOLS.len(); i++) begin
         if (SYMBOLS[i] == c) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic add_tok(input logic [POS_W-1:0] s, input logic [POS_W-1:0] l,
                          input logic [2:0] k, input logic [7:0] f, input logic o);
      satok_pkg::rsp_payload_type t;
      if (step_toks.size() < satok_pkg::MAX_RESULTS) begin
         t.token_start  = s;
         t.token_length = l;
         t.token_kind   = k;
         t.first_byte   = f;
         t.overflow     = o;
         t.run_last     = 1'b0;
         step_toks.push_back(t);
      end
   endtask

   // resolve the held form against c, then classify c itself
   task automatic scan_byte(inout satok_pkg::mode_type m, inout logic [POS_W-1:0] st,
                            inout logic [7:0] hd, input logic [7:0] c,
                            input logic [POS_W-1:0] p, input logic brk);
      satok_pkg::mode_type was;
      logic                go;
      was = m;
      m   = satok_pkg::MODE_IDLE;
      go  = 1'b1;
      case (was)
         satok_pkg::MODE_B: begin
            if (c == satok_pkg::CH_LOWER_R) begin
               add_tok(st, POS_W'(2), satok_pkg::KIND_BR, satok_pkg::CH_UPPER_B, 1'b0);
               go = 1'b0;
            end else begin
               add_tok(st, POS_W'(1), satok_pkg::KIND_B, satok_pkg::CH_UPPER_B, 1'b0);
            end
         end
         satok_pkg::MODE_C: begin
            if (c == satok_pkg::CH_LOWER_L) begin
               add_tok(st, POS_W'(2), satok_pkg::KIND_CL, satok_pkg::CH_UPPER_C, 1'b0);
               go = 1'b0;
            end else begin
               add_tok(st, POS_W'(1), satok_pkg::KIND_C, satok_pkg::CH_UPPER_C, 1'b0);
            end
         end
         satok_pkg::MODE_PCT: begin
            if (is_num(c)) begin
               m  = satok_pkg::MODE_PCT1;
               hd = c;
               go = 1'b0;
            end
         end
         satok_pkg::MODE_PCT1: begin
            if (is_num(c)) begin
               add_tok(st, POS_W'(3), satok_pkg::KIND_PERCENT, satok_pkg::CH_PERCENT, 1'b0);
               go = 1'b0;
            end else begin
               add_tok(st + 1'b1, POS_W'(1), satok_pkg::KIND_DIGIT, hd, 1'b0);
            end
         end
         default: begin
         end
      endcase
      if (go) begin
         if (c == satok_pkg::CH_UPPER_B) begin
            m  = satok_pkg::MODE_B;
            st = p;
         end else if (c == satok_pkg::CH_UPPER_C) begin
            m  = satok_pkg::MODE_C;
            st = p;
         end else if (c == satok_pkg::CH_PERCENT) begin
            m  = satok_pkg::MODE_PCT;
            st = p;
         end else if (c == satok_pkg::CH_LBRACK && brk) begin
            m  = satok_pkg::MODE_BRACKET;
            st = p;
         end else if (is_num(c)) begin
            add_tok(p, POS_W'(1), satok_pkg::KIND_DIGIT, c, 1'b0);
         end else if (is_sym(c)) begin
            add_tok(p, POS_W'(1), satok_pkg::KIND_SINGLE, c, 1'b0);
         end
      end
   endtask

   // end of input: B and C stand alone, percent plus one digit leaves the digit
   task automatic close_held(input satok_pkg::mode_type m, input logic [POS_W-1:0] st,
                             input logic [7:0] hd);
      case (m)
         satok_pkg::MODE_B:
            add_tok(st, POS_W'(1), satok_pkg::KIND_B, satok_pkg::CH_UPPER_B, 1'b0);
         satok_pkg::MODE_C:
            add_tok(st, POS_W'(1), satok_pkg::KIND_C, satok_pkg::CH_UPPER_C, 1'b0);
         satok_pkg::MODE_PCT1:
            add_tok(st + 1'b1, POS_W'(1), satok_pkg::KIND_DIGIT, hd, 1'b0);
         default: begin
         end
      endcase
   endtask

   task automatic predict_tokens(input logic [7:0] c, input logic eos);
      logic [POS_W-1:0]    p;
      logic [POS_W-1:0]    first;
      logic [POS_W-1:0]    rs_start;
      logic [7:0]          rs_held;
      logic [7:0]          held;
      satok_pkg::mode_type rs_mode;
      int                  n;
      step_toks.delete();
      p = str_pos;
      if (held_mode == satok_pkg::MODE_BRACKET) begin
         if (c == satok_pkg::CH_RBRACK) begin
            if (bracket_len > 0) begin
               add_tok(held_start, p - held_start + 1'b1, satok_pkg::KIND_BRACKET,
                       satok_pkg::CH_LBRACK, 1'b0);
            end
            held_mode   = satok_pkg::MODE_IDLE;
            bracket_len = 0;
         end else begin
            if (bracket_len < DEPTH) begin
               bracket_buf[bracket_len] = c;
            end
            if (bracket_len <= DEPTH) begin
               bracket_len++;
            end
         end
      end else begin
         // a percent with one digit keeps the digit in entry zero
         held = bracket_buf[0];
         scan_byte(held_mode, held_start, held, c, p, 1'b1);
         bracket_buf[0] = held;
         if (held_mode == satok_pkg::MODE_BRACKET) begin
            bracket_len = 0;
         end
      end
      if (eos) begin
         if (held_mode == satok_pkg::MODE_BRACKET) begin
            rs_mode  = satok_pkg::MODE_IDLE;
            rs_start = '0;
            rs_held  = '0;
            n = (bracket_len < DEPTH) ? bracket_len : DEPTH;
            for (int i = 0; i < n; i++) begin
               scan_byte(rs_mode, rs_start, rs_held, bracket_buf[i],
                         held_start + POS_W'(1 + i), 1'b0);
            end
            close_held(rs_mode, rs_start, rs_held);
            if (bracket_len > DEPTH) begin
               first = held_start + POS_W'(1 + DEPTH);
               add_tok(first, p - first + 1'b1, satok_pkg::KIND_BRACKET,
                       satok_pkg::CH_NUL, 1'b1);
            end
         end else begin
            close_held(held_mode, held_start, bracket_buf[0]);
         end
         str_pos     = '0;
         held_mode   = satok_pkg::MODE_IDLE;
         held_start  = '0;
         bracket_len = 0;
      end else begin
         str_pos = p + 1'b1;
      end
      if (step_toks.size() > 0) begin
         step_toks[step_toks.size() - 1].run_last = 1'b1;
      end
      foreach (step_toks[i]) begin
         expected_toks.push_back(step_toks[i]);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want !== got) begin
         errors++;
         $display("%0t: token %0d %s expected %0h, got %0h", $time, checked, name,
                  want, got);
      end
   endtask

   always @(posedge clock) begin
      satok_pkg::rsp_payload_type want;
      if (reset) begin
         str_pos     = '0;
         held_mode   = satok_pkg::MODE_IDLE;
         held_start  = '0;
         bracket_len = 0;
         expected_toks.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_tokens(req_payload.ch, req_payload.end_of_string);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_toks.size() == 0) begin
               errors++;
               $display("%0t: unexpected token, expected none, got %h", $time,
                        rsp_payload);
            end else begin
               want = expected_toks.pop_front();
               check_field("start", want.token_start, rsp_payload.token_start);
               check_field("length", want.token_length, rsp_payload.token_length);
               check_field("kind", want.token_kind, rsp_payload.token_kind);
               check_field("first_byte", want.first_byte, rsp_payload.first_byte);
               check_field("overflow", want.overflow, rsp_payload.overflow);
               check_field("run_last", want.run_last, rsp_payload.run_last);
               if (want.overflow) begin
                  markers++;
               end
               checked++;
            end
         end
      end
      fail_count    <= errors;
      pending_count <= expected_toks.size();
      token_count   <= checked;
      marker_count  <= markers;
   end

endmodule

### tb/tb_smiles_atomwise_tokenizer_core.sv
// Testbench top: clock, reset, byte-string stimulus with idling, and the final verdict.
`timescale 1ns / 1ps

module tb_smiles_atomwise_tokenizer_core;

   localparam int    DEPTH   = 32;
   localparam string SYMBOLS = "NOSPFIbcnosp().=#-+\\/:~@?>*$";
   localparam string INNER   = "BCl%0123456789rNOSc([H+@";

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   satok_pkg::req_payload_type req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   satok_pkg::rsp_payload_type rsp_payload;

   int fail_count;
   int pending_count;
   int token_count;
   int marker_count;

   int sender_idle_pct = 7;
   int rsp_idle_pct    = 70;
   int items_sent      = 0;
   int strings_sent    = 0;

   logic [7:0] text[$];

   always #5 clock = ~clock;

   smiles_atomwise_tokenizer_core #(
      .BRACKET_DEPTH(DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   satok_token_checker #(
      .DEPTH(DEPTH)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .token_count  (token_count),
      .marker_count (marker_count)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   task automatic put_text(input string t);
      for (int i = 0; i < t.len(); i++) begin
         text.push_back(t[i]);
      end
   endtask

   task automatic put_byte(input logic [7:0] c);
      text.push_back(c);
   endtask

   task automatic put_digit();
      put_byte(satok_pkg::CH_DIGIT_0 + 8'($urandom_range(9)));
   endtask

   task automatic put_inner();
      if ($urandom_range(3) == 0) begin
         put_byte(8'($urandom_range(255)));
      end else begin
         put_byte(INNER[$urandom_range(INNER.len() - 1)]);
      end
   endtask

   task automatic put_piece();
      case ($urandom_range(19))
         0, 1: put_text("C");
         2: put_text("Cl");
         3: put_text("Br");
         4: put_text("B");
         5, 6, 7: put_byte(SYMBOLS[$urandom_range(SYMBOLS.len() - 1)]);
         8, 9: put_digit();
         10: begin
            put_byte(satok_pkg::CH_PERCENT);
            put_digit();
            put_digit();
         end
         11: begin
            put_byte(satok_pkg::CH_PERCENT);
            put_digit();
         end
         12: put_byte(satok_pkg::CH_PERCENT);
         13, 14: begin
            put_byte(satok_pkg::CH_LBRACK);
            repeat ($urandom_range(1, 5)) put_inner();
            put_byte(satok_pkg::CH_RBRACK);
         end
         15: put_text("[]");
         16, 17: put_byte(8'($urandom_range(255)));
         default: put_text("c1");
      endcase
   endtask

   // mostly well-formed pieces; some strings end inside a bracket, a few overflow it
   task automatic build_random();
      repeat ($urandom_range(1, 8)) put_piece();
      case ($urandom_range(11))
         0, 1: begin
            put_byte(satok_pkg::CH_LBRACK);
            repeat ($urandom_range(0, 8)) put_inner();
         end
         2: begin
            if ($urandom_range(1)) begin
               // every stored pair yields two tokens, and the pairs overflow the bracket store
               put_text("B[");
               repeat (17) put_text("B1");
            end else begin
               put_byte(satok_pkg::CH_LBRACK);
               repeat ($urandom_range(DEPTH + 1, DEPTH + 13)) put_inner();
            end
         end
         3: begin
            put_byte(satok_pkg::CH_LBRACK);
            repeat ($urandom_range(DEPTH - 2, DEPTH + 8)) begin
               put_byte(INNER[$urandom_range(INNER.len() - 1)]);
            end
            put_byte(satok_pkg::CH_RBRACK);
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_item(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{ch: c, end_of_string: last};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
      if (items_sent == 140) begin
         sender_idle_pct = 70;
         rsp_idle_pct    = 7;
      end else if (items_sent == 280) begin
         sender_idle_pct = 0;
         rsp_idle_pct    = 0;
      end
   endtask

   task automatic send_text();
      foreach (text[i]) begin
         send_item(text[i], i == text.size() - 1);
      end
      text.delete();
      strings_sent++;
   endtask

   initial begin
      #2_000_000;
      $display("[smiles_atomwise_tokenizer_core] ERROR");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every token kind but bracket and single-symbol, a percent with one digit resolved by a later byte
      put_text("BrBCCl%12%3x7");
      send_text();
      // empty bracket, NUL and 0xFF skipped, B held at the end
      put_text("[]");
      put_byte(satok_pkg::CH_NUL);
      put_byte(8'hFF);
      put_text("B");
      send_text();
      put_text("C");
      send_text();
      // lone percent at the end is dropped
      put_text("%");
      send_text();
      put_text("%5");
      send_text();
      // unclosed bracket: rescan skips the inner bracket, C held at buffer end
      put_text("[B[C");
      send_text();

      while (items_sent < 420) begin
         build_random();
         send_text();
      end

      req_valid <= 1'b0;
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (4 * DEPTH + 20) @(posedge clock);

      $display("run covered %0d bytes in %0d strings, three idling phases",
               items_sent, strings_sent);
      $display("%0d tokens compared, %0d of them bracket overflow markers",
               token_count, marker_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[smiles_atomwise_tokenizer_core] OK");
      end else begin
         $display("[smiles_atomwise_tokenizer_core] ERROR");
      end
      $finish;
   end

endmodule
